@@ hw/rtl/cit_pkg.sv @@
// Channel interval timer: shared types, constants and config check.
// No dependencies; compiled first.
`default_nettype none

package cit_pkg;

  // Field widths
  localparam int unsigned IntW  = 10;  // interval registers
  localparam int unsigned TimeW = 11;  // positions and distances in a cycle
  localparam int unsigned LookW = 16;  // lookahead offset
  localparam int unsigned SumW  = 17;  // position plus lookahead

  // Register reset values
  localparam logic [IntW-1:0] CchReset   = 10'd50;
  localparam logic [IntW-1:0] SchReset   = 10'd50;
  localparam logic [IntW-1:0] GuardReset = 10'd4;

  typedef logic [1:0] cfg_idx_t;

  // Register indexes of the config port
  typedef enum logic [1:0] {
    REG_CCH   = 2'd0,
    REG_SCH   = 2'd1,
    REG_GUARD = 2'd2,
    REG_RUN   = 2'd3
  } cit_reg_e;

  // Slot-start event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_GUARD = 2'd1,
    EV_CCH   = 2'd2,
    EV_SCH   = 2'd3
  } ev_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } cit_state_e;

  // One result beat
  typedef struct packed {
    ev_kind_e          event_kind;
    logic [IntW-1:0]   event_length_ms;
    logic              guard_in_cch;
    logic              query_in_cch;
    logic              query_in_guard;
    logic [TimeW-1:0]  time_to_cch_ms;
    logic [TimeW-1:0]  time_to_sch_ms;
    logic [TimeW-1:0]  time_to_guard_ms;
    logic [TimeW-1:0]  remain_ms;
    logic              config_error;
  } cit_res_t;

  // True when the sync length divides one second (1000 ms)
  function automatic logic divides_second(input logic [TimeW-1:0] sync);
    logic ok;
    case (sync) inside
      11'd1, 11'd2, 11'd4, 11'd5, 11'd8, 11'd10, 11'd20, 11'd25, 11'd40,
      11'd50, 11'd100, 11'd125, 11'd200, 11'd250, 11'd500, 11'd1000: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cit_in_if.sv @@
// Tick channel: valid/ready handshake carrying the lookahead offset.
// No dependencies.
`default_nettype none

interface cit_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] lookahead_ms;

  modport source (output valid, output lookahead_ms, input ready);
  modport sink   (input valid, input lookahead_ms, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cit_out_if.sv @@
// Result channel: valid/ready handshake carrying one timer report.
// No dependencies.
`default_nettype none

interface cit_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [9:0]  event_length_ms;
  logic        guard_in_cch;
  logic        query_in_cch;
  logic        query_in_guard;
  logic [10:0] time_to_cch_ms;
  logic [10:0] time_to_sch_ms;
  logic [10:0] time_to_guard_ms;
  logic [10:0] remain_ms;
  logic        config_error;

  modport source (
    output valid, event_kind, event_length_ms, guard_in_cch, query_in_cch,
    output query_in_guard, time_to_cch_ms, time_to_sch_ms, time_to_guard_ms,
    output remain_ms, config_error,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_length_ms, guard_in_cch, query_in_cch,
    input  query_in_guard, time_to_cch_ms, time_to_sch_ms, time_to_guard_ms,
    input  remain_ms, config_error,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/cit_mod_unit.sv @@
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on cit_pkg.
`default_nettype none

module cit_mod_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [cit_pkg::SumW-1:0]  dividend_i,
  input  wire logic [cit_pkg::TimeW-1:0] divisor_i,
  output logic                           done_o,
  output logic [cit_pkg::TimeW-1:0]      rem_o
);
  import cit_pkg::*;

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0]  shift_q, shift_d;
  logic [TimeW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [TimeW:0]   trial;
  logic [TimeW:0]   diff;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem_q, shift_q[SumW-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shift_d = dividend_i;
      rem_d   = '0;
      cnt_d   = CntW'(SumW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = {shift_q[SumW-2:0], 1'b0};
      rem_d   = (trial >= {1'b0, divisor_i}) ? diff[TimeW-1:0] : trial[TimeW-1:0];
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/channel_interval_timer.sv @@
// Channel interval timer top level: config registers, cycle position,
// query evaluation and result register. Depends on cit_pkg, cit_in_if,
// cit_out_if and cit_mod_unit.
//
//  channel   dir  payload                         beat
//  in_i      in   lookahead_ms                    one ms tick
//  out_o     out  event and query report fields   one report per tick
//  cfg_*     in   cfg_idx_i, cfg_data_i           write, no handshake
//
// Each tick is handled in order: the remainder unit is loaded, computes the
// bit-serial remainder of (position + lookahead) by the sync length (one bit
// of the 17-bit sum per cycle), hands the remainder over, and the report is
// formed. The next tick can be accepted in the same cycle as the report
// appears. An invalid config skips the remainder and goes from accept straight
// to the report state. Reset restores the register defaults and position zero.
// A stalled result waits in the output register; the next tick may be
// accepted meanwhile.
`default_nettype none

module channel_interval_timer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire cit_pkg::cfg_idx_t cfg_idx_i,
  input  wire logic [9:0]        cfg_data_i,
  cit_in_if.sink                 in_i,
  cit_out_if.source              out_o
);
  import cit_pkg::*;

  // Configuration registers
  logic [IntW-1:0]  cch_q, sch_q, guard_q;
  logic             run_q;
  logic [TimeW-1:0] sync;
  logic             cfg_ok;

  // Control and position
  cit_state_e       state_q, state_d;
  logic [TimeW-1:0] pos_q, pos_d;
  logic [TimeW-1:0] pos_eff;
  logic [TimeW-1:0] pos_inc;
  logic [LookW-1:0] look_q;
  logic             out_valid_q, out_valid_d;
  cit_res_t         res_q, res_d;

  // Remainder unit hookup
  logic             start_q;
  logic             div_start;
  logic             div_done;
  logic [SumW-1:0]  div_sum;
  logic [TimeW-1:0] q_pos;

  // Query terms
  logic [TimeW-1:0] cch_w, gi_w;
  logic             q_cch;
  logic [TimeW-1:0] q_rel;
  logic             q_guard;

  logic in_acc;
  logic out_free;

  assign sync   = {1'b0, cch_q} + {1'b0, sch_q};
  assign cfg_ok = (cch_q != '0) && (sch_q != '0) && (guard_q != '0) &&
                  divides_second(sync) && (cch_q > guard_q) && (sch_q > guard_q);

  assign cch_w = {1'b0, cch_q};
  assign gi_w  = {1'b0, guard_q};

  // A position left beyond a shortened cycle counts as zero
  assign pos_eff = (pos_q >= sync) ? '0 : pos_q;
  assign pos_inc = pos_eff + 1'b1;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign div_sum = {{(SumW-TimeW){1'b0}}, pos_eff} + {1'b0, look_q};

  // Remainder starts the cycle after accept, once the lookahead is latched
  assign div_start = start_q;

  cit_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_sum),
    .divisor_i  (sync),
    .done_o     (div_done),
    .rem_o      (q_pos)
  );

  // Query classification of the remainder
  assign q_cch   = (q_pos < cch_w);
  assign q_rel   = q_cch ? q_pos : (q_pos - cch_w);
  assign q_guard = (q_rel < gi_w);

  // Report assembly
  always_comb begin
    res_d = '0;
    if (!cfg_ok) begin
      res_d.config_error = 1'b1;
    end else begin
      res_d.event_kind = EV_NONE;
      if (run_q) begin
        if (pos_eff == '0) begin
          res_d.event_kind      = EV_GUARD;
          res_d.event_length_ms = guard_q;
          res_d.guard_in_cch    = 1'b1;
        end else if (pos_eff == gi_w) begin
          res_d.event_kind      = EV_CCH;
          res_d.event_length_ms = cch_q - guard_q;
        end else if (pos_eff == cch_w) begin
          res_d.event_kind      = EV_GUARD;
          res_d.event_length_ms = guard_q;
        end else if (pos_eff == cch_w + gi_w) begin
          res_d.event_kind      = EV_SCH;
          res_d.event_length_ms = sch_q - guard_q;
        end
      end
      res_d.query_in_cch     = q_cch;
      res_d.query_in_guard   = q_guard;
      res_d.time_to_cch_ms   = q_cch ? '0 : (sync - q_pos);
      res_d.time_to_sch_ms   = q_cch ? (cch_w - q_pos) : '0;
      res_d.time_to_guard_ms = q_guard ? '0 : (q_cch ? (cch_w - q_pos) : (sync - q_pos));
      res_d.remain_ms        = sync - q_pos;
    end
  end

  // Sequencer: accept, remainder, report
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cfg_ok) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (cfg_ok) begin
            if (run_q) begin
              pos_d = (pos_inc >= sync) ? '0 : pos_inc;
            end else begin
              pos_d = pos_eff;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i && cit_reg_e'(cfg_idx_i) == REG_RUN) begin
      pos_d = '0;
    end
  end

  // Kick the remainder unit in the cycle after accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= in_acc && cfg_ok;
    end
  end

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cch_q   <= CchReset;
      sch_q   <= SchReset;
      guard_q <= GuardReset;
      run_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cit_reg_e'(cfg_idx_i))
        REG_CCH:   cch_q   <= cfg_data_i;
        REG_SCH:   sch_q   <= cfg_data_i;
        REG_GUARD: guard_q <= cfg_data_i;
        REG_RUN:   run_q   <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  // Control state and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      look_q <= in_i.lookahead_ms;
    end
    if (state_q == ST_DONE && out_free) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.event_kind       = res_q.event_kind;
  assign out_o.event_length_ms  = res_q.event_length_ms;
  assign out_o.guard_in_cch     = res_q.guard_in_cch;
  assign out_o.query_in_cch     = res_q.query_in_cch;
  assign out_o.query_in_guard   = res_q.query_in_guard;
  assign out_o.time_to_cch_ms   = res_q.time_to_cch_ms;
  assign out_o.time_to_sch_ms   = res_q.time_to_sch_ms;
  assign out_o.time_to_guard_ms = res_q.time_to_guard_ms;
  assign out_o.remain_ms        = res_q.remain_ms;
  assign out_o.config_error     = res_q.config_error;

`ifndef SYNTH
  // The remainder unit only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("remainder done outside of DIV state");

  // A new result appears only out of the report state
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid raised outside of DONE state");

  // A config error report carries no event and no query answer
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.config_error |->
      res_q.event_kind == EV_NONE && res_q.remain_ms == '0)
    else $error("config error report carries event or query data");
`endif

endmodule

`default_nettype wire

@@ bench/tb_channel_interval_timer.sv @@
// Self-checking bench for channel_interval_timer: drives ticks and config writes
// and checks every report beat against a model of the timer's reports.
// Depends on cit_pkg, cit_in_if, cit_out_if and the channel_interval_timer RTL.
`timescale 1ns / 100ps

module tb_channel_interval_timer;
  import cit_pkg::*;

  localparam int unsigned QuietLimit = 1000;  // cycles without any beat
  localparam int unsigned TailCycles = 25;    // settle time after last report

  // Report scoreboard: timer state copy, expected reports, field compare
  class timer_report_board;
    int unsigned cch_ms;
    int unsigned sch_ms;
    int unsigned guard_ms;
    bit          running;
    int unsigned position;
    cit_res_t    expected_reports[$];
    int unsigned errors;

    function new();
      cch_ms   = 32'(CchReset);
      sch_ms   = 32'(SchReset);
      guard_ms = 32'(GuardReset);
      running  = 1'b0;
      position = 0;
      errors   = 0;
    endfunction

    function void write_reg(cit_reg_e idx, logic [IntW-1:0] val);
      case (idx)
        REG_CCH:   cch_ms = 32'(val);
        REG_SCH:   sch_ms = 32'(val);
        REG_GUARD: guard_ms = 32'(val);
        REG_RUN: begin
          running  = val[0];
          position = 0;
        end
        default: ;
      endcase
    endfunction

    function bit intervals_ok();
      int unsigned span;
      span = cch_ms + sch_ms;
      if (cch_ms == 0 || sch_ms == 0 || guard_ms == 0) return 1'b0;
      if ((1000 % span) != 0) return 1'b0;
      if (cch_ms <= guard_ms || sch_ms <= guard_ms) return 1'b0;
      return 1'b1;
    endfunction

    // Report for one tick; advances the cycle position when running
    function cit_res_t predict_report(logic [LookW-1:0] look);
      cit_res_t    r;
      int unsigned span, p, q, rel;
      r = '0;
      r.event_kind = EV_NONE;
      span = cch_ms + sch_ms;
      if (!intervals_ok()) begin
        r.config_error = 1'b1;
        return r;
      end
      if (position >= span) position = 0;
      p = position;

      // slot starts at the current position
      if (running) begin
        if (p == 0) begin
          r.event_kind = EV_GUARD;
          r.event_length_ms = IntW'(guard_ms);
          r.guard_in_cch = 1'b1;
        end else if (p == guard_ms) begin
          r.event_kind = EV_CCH;
          r.event_length_ms = IntW'(cch_ms - guard_ms);
        end else if (p == cch_ms) begin
          r.event_kind = EV_GUARD;
          r.event_length_ms = IntW'(guard_ms);
        end else if (p == cch_ms + guard_ms) begin
          r.event_kind = EV_SCH;
          r.event_length_ms = IntW'(sch_ms - guard_ms);
        end
      end

      // queries at the looked-ahead time
      q = (p + look) % span;
      r.query_in_cch = (q < cch_ms);
      rel = r.query_in_cch ? q : q - cch_ms;
      r.query_in_guard = (rel < guard_ms);
      r.time_to_cch_ms = TimeW'(r.query_in_cch ? 0 : span - q);
      r.time_to_sch_ms = TimeW'(r.query_in_cch ? cch_ms - q : 0);
      if (r.query_in_guard) r.time_to_guard_ms = '0;
      else if (r.query_in_cch) r.time_to_guard_ms = TimeW'(cch_ms - q);
      else r.time_to_guard_ms = TimeW'(span - q);
      r.remain_ms = TimeW'(span - q);

      if (running) position = (p + 1 >= span) ? 0 : p + 1;
      return r;
    endfunction

    function void note_tick(logic [LookW-1:0] look);
      expected_reports.insert(expected_reports.size(), predict_report(look));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_report(cit_res_t got);
      cit_res_t want;
      if (expected_reports.size() == 0) begin
        $error("report beat with no tick pending");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
      compare_field("event_length_ms", 32'(want.event_length_ms),
                    32'(got.event_length_ms));
      compare_field("guard_in_cch", 32'(want.guard_in_cch), 32'(got.guard_in_cch));
      compare_field("query_in_cch", 32'(want.query_in_cch), 32'(got.query_in_cch));
      compare_field("query_in_guard", 32'(want.query_in_guard),
                    32'(got.query_in_guard));
      compare_field("time_to_cch_ms", 32'(want.time_to_cch_ms),
                    32'(got.time_to_cch_ms));
      compare_field("time_to_sch_ms", 32'(want.time_to_sch_ms),
                    32'(got.time_to_sch_ms));
      compare_field("time_to_guard_ms", 32'(want.time_to_guard_ms),
                    32'(got.time_to_guard_ms));
      compare_field("remain_ms", 32'(want.remain_ms), 32'(got.remain_ms));
      compare_field("config_error", 32'(want.config_error), 32'(got.config_error));
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  cfg_idx_t        cfg_idx_i;
  logic [IntW-1:0] cfg_data_i;
  bit              idle_on;

  cit_in_if  tick_ch ();
  cit_out_if rep_ch ();

  timer_report_board board;

  channel_interval_timer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tick_ch),
    .out_o      (rep_ch)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Report side: random stall bursts while idle_on is set, check each accepted beat
  initial begin
    int unsigned stall_left;
    cit_res_t    got;
    stall_left = 0;
    rep_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rep_ch.valid && rep_ch.ready) begin
        got.event_kind       = ev_kind_e'(rep_ch.event_kind);
        got.event_length_ms  = rep_ch.event_length_ms;
        got.guard_in_cch     = rep_ch.guard_in_cch;
        got.query_in_cch     = rep_ch.query_in_cch;
        got.query_in_guard   = rep_ch.query_in_guard;
        got.time_to_cch_ms   = rep_ch.time_to_cch_ms;
        got.time_to_sch_ms   = rep_ch.time_to_sch_ms;
        got.time_to_guard_ms = rep_ch.time_to_guard_ms;
        got.remain_ms        = rep_ch.remain_ms;
        got.config_error     = rep_ch.config_error;
        board.check_report(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) rep_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rep_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 5);
      end else begin
        rep_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after too long without a beat on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (tick_ch.valid && tick_ch.ready) || (rep_ch.valid && rep_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_channel_interval_timer: done, errors");
    $finish;
  end

  // One tick beat, with an optional idle burst ahead of it
  task automatic send_tick(input logic [LookW-1:0] look);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.lookahead_ms <= look;
    do @(posedge clk_i); while (!tick_ch.ready);
    board.note_tick(look);
  endtask

  // Hold off ticks until every pending report has come back
  task automatic drain_reports();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (board.expected_reports.size() != 0);
  endtask

  task automatic cfg_write(input cit_reg_e idx, input logic [IntW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  // Intervals always written; run flag only when asked (a run write restarts)
  task automatic configure(input logic [IntW-1:0] cch, input logic [IntW-1:0] sch,
                           input logic [IntW-1:0] guard, input bit set_run,
                           input bit run_val);
    drain_reports();
    cfg_write(REG_CCH, cch);
    cfg_write(REG_SCH, sch);
    cfg_write(REG_GUARD, guard);
    if (set_run) cfg_write(REG_RUN, {{(IntW-1){1'b0}}, run_val});
    cfg_we_i <= 1'b0;
  endtask

  // Half the offsets up to twice the span plus two, the rest full-range and edge values
  function automatic logic [LookW-1:0] pick_lookahead();
    int unsigned span;
    span = board.cch_ms + board.sch_ms;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return LookW'($urandom());
      default: return LookW'($urandom_range(0, 2 * span + 2));
    endcase
  endfunction

  task automatic run_ticks(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_tick(pick_lookahead());
  endtask

  // Random config: mostly valid cycles dividing one second, some raw values
  task automatic random_config();
    int unsigned spans[14] = '{4, 5, 8, 10, 20, 25, 40, 50, 100, 125, 200, 250, 500, 1000};
    int unsigned span, cch, sch, lo;
    if ($urandom_range(0, 9) == 0) begin
      configure(IntW'($urandom()), IntW'($urandom()), IntW'($urandom()), 1'b1, 1'b1);
    end else begin
      span = spans[$urandom_range(0, 13)];
      cch = $urandom_range(2, span - 2);
      sch = span - cch;
      lo = (cch < sch) ? cch : sch;
      configure(IntW'(cch), IntW'(sch), IntW'($urandom_range(1, lo - 1)),
                $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0);
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [LookW-1:0] idle_looks[8] = '{0, 16'hFFFF, 49, 50, 53, 54, 99, 100};
    logic [LookW-1:0] run_looks[12] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 16'hFFFF, 10};

    board = new();
    idle_on = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_CCH;
    cfg_data_i <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.lookahead_ms <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config, not running: queries from a held position
    foreach (idle_looks[i]) send_tick(idle_looks[i]);

    // short cycle, running: every slot start in ten ticks
    configure(5, 5, 2, 1'b1, 1'b1);
    foreach (run_looks[i]) send_tick(run_looks[i]);

    // invalid configs: zero interval, zero guard, interval not above guard,
    // cycle not dividing a second, out-of-range values
    configure(0, 5, 2, 1'b0, 1'b0);     send_tick(16'h1234);
    configure(5, 5, 0, 1'b0, 1'b0);     send_tick(16'h00FF);
    configure(5, 5, 5, 1'b0, 1'b0);     send_tick(16'hFF00);
    configure(8, 2, 2, 1'b0, 1'b0);     send_tick(3);
    configure(3, 4, 1, 1'b0, 1'b0);     send_tick(6);
    configure(1000, 1000, 4, 1'b0, 1'b0); send_tick(16'hFFFF);
    configure(1023, 1023, 1023, 1'b0, 1'b0); send_tick(0);

    idle_on = 1'b1;

    // position beyond a shortened cycle falls back to zero
    configure(50, 50, 4, 1'b1, 1'b1);
    run_ticks(60);
    configure(10, 10, 4, 1'b0, 1'b0);
    run_ticks(30);

    // extreme cycles
    configure(500, 500, 1, 1'b1, 1'b1);   run_ticks(40);
    configure(500, 500, 499, 1'b1, 1'b1); run_ticks(40);
    configure(998, 2, 1, 1'b1, 1'b1);     run_ticks(40);
    configure(2, 998, 1, 1'b1, 1'b1);     run_ticks(40);
    configure(2, 2, 1, 1'b1, 1'b1);       run_ticks(40);

    // random configs; one pause mid-phase until all reports are back
    for (int unsigned ph = 0; ph < 12; ph++) begin
      random_config();
      run_ticks(20);
      if (ph == 3) drain_reports();
      run_ticks(20);
    end

    // last stretch at full rate
    configure(10, 10, 3, 1'b1, 1'b1);
    idle_on = 1'b0;
    run_ticks(80);

    drain_reports();
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.expected_reports.size() == 0)
      $display("tb_channel_interval_timer: done, clean");
    else
      $display("tb_channel_interval_timer: done, errors");
    $finish;
  end

endmodule
